[rtl/core/lcfb_pkg.sv]
// Shared types and constants for the length-prefixed CRC-16 frame builder.
// Has no dependencies. Used by lcfb_crc16 and length_crc16_frame_builder.
package lcfb_pkg;

	// Widths fixed by the beat fields and the byte store.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CNT_W   = 8;
	localparam int unsigned CRC_W   = 16;
	localparam int unsigned STORE_D = 1 << CNT_W;

	// CRC-16/CCITT-FALSE constants.
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam logic [CNT_W-1:0] LEN_EXTRA = 8'd2;

	// Command codes.
	typedef enum logic {
		CMD_APPEND = 1'b0,
		CMD_READ   = 1'b1
	} command_t;

	// Status codes returned with every result.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_BUSY  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Control sequencer states.
	typedef enum logic {
		S_IDLE  = 1'b0,
		S_FETCH = 1'b1
	} state_t;

	// Input beat.
	typedef struct packed {
		command_t          command;
		logic [BYTE_W-1:0] data_byte;
	} cmd_t;

	// Output beat.
	typedef struct packed {
		logic              out_valid;
		logic [BYTE_W-1:0] out_byte;
		logic              out_last;
		status_t           status;
	} rsp_t;

endpackage

[rtl/core/lcfb_crc16.sv]
// Byte-wide CRC-16/CCITT-FALSE update: an eight-step shift and XOR network.
// Depends on lcfb_pkg.
module lcfb_crc16 (
	input  logic [lcfb_pkg::CRC_W-1:0]  crc_in,
	input  logic [lcfb_pkg::BYTE_W-1:0] data_in,
	output logic [lcfb_pkg::CRC_W-1:0]  crc_out
);
	import lcfb_pkg::*;

	// Fold the byte into the top of the register, then shift out eight bits.
	always_comb begin
		logic [CRC_W-1:0] c;
		c = crc_in ^ {data_in, {(CRC_W-BYTE_W){1'b0}}};
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

[rtl/core/length_crc16_frame_builder.sv]
// Frame builder top level: payload store, CRC register and frame sequencer.
// Depends on lcfb_pkg and lcfb_crc16.
//
// Usage: each beat on the cmd channel either appends a payload byte or asks
// for the next byte of the frame. Every command beat yields exactly one beat
// on the rsp channel. A frame is sent as a length byte (payload count plus
// two), the payload bytes in order, the CRC low byte and the CRC high byte,
// which carries out_last. Appends during emission or beyond MAX_PAYLOAD bytes
// are dropped and flagged in the status field.
// Appends, length and CRC reads load the output register directly from the
// accepted command; a payload read passes through the store's registered read
// port and the S_FETCH state first. Throughput is one beat per cycle while
// rsp_stall is low, except payload reads, which block new commands in S_FETCH.
// A command is taken while a previous response still waits, provided that
// response is taken in the same cycle; with rsp_stall high the output register
// holds its beat and cmd_stall rises.
// Reset clears the count, CRC, emit position and output valid at once; the
// payload store is not cleared, since only bytes written for the current
// frame are ever read.
module length_crc16_frame_builder #(
	parameter int unsigned MAX_PAYLOAD = 253
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  lcfb_pkg::cmd_t   cmd,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output lcfb_pkg::rsp_t   rsp
);
	import lcfb_pkg::*;

	localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_PAYLOAD);

	// Payload store and its registered read data.
	logic [BYTE_W-1:0] store_q [STORE_D];
	logic [BYTE_W-1:0] rd_data_s1;

	// Frame state.
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CRC_W-1:0]  crc_q;
	logic [CNT_W-1:0]  pos_q;
	logic              emitting_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// Control decisions for this cycle.
	logic              accept;
	logic              slot_free;
	logic              do_append;
	logic              do_read;
	logic              do_advance;
	logic              do_clear;
	logic              load_rsp;
	rsp_t              rsp_d;
	logic [CRC_W-1:0]  crc_next;
	logic [CNT_W-1:0]  rd_addr;

	lcfb_crc16 u_crc (
		.crc_in  (crc_q),
		.data_in (cmd.data_byte),
		.crc_out (crc_next)
	);

	// The output register can take a new beat when empty or being drained.
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE) || !slot_free;
	assign accept    = cmd_valid && !cmd_stall;
	assign rd_addr   = pos_q - CNT_W'(1);

	// Sequencer: decode the accepted command and build the response.
	always_comb begin
		state_d    = state_q;
		do_append  = 1'b0;
		do_read    = 1'b0;
		do_advance = 1'b0;
		do_clear   = 1'b0;
		load_rsp   = 1'b0;
		rsp_d      = '{out_valid: 1'b0, out_byte: '0, out_last: 1'b0, status: ST_OK};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd.command == CMD_APPEND) begin
						load_rsp = 1'b1;
						if (emitting_q) begin
							rsp_d.status = ST_BUSY;
						end else if (count_q >= MaxCount) begin
							rsp_d.status = ST_FULL;
						end else begin
							do_append = 1'b1;
						end
					end else if (!emitting_q && count_q == '0) begin
						load_rsp     = 1'b1;
						rsp_d.status = ST_EMPTY;
					end else if (pos_q == '0) begin
						load_rsp        = 1'b1;
						do_advance      = 1'b1;
						rsp_d.out_valid = 1'b1;
						rsp_d.out_byte  = count_q + LEN_EXTRA;
					end else if (pos_q <= count_q) begin
						do_read    = 1'b1;
						do_advance = 1'b1;
						state_d    = S_FETCH;
					end else if (pos_q == count_q + CNT_W'(1)) begin
						load_rsp        = 1'b1;
						do_advance      = 1'b1;
						rsp_d.out_valid = 1'b1;
						rsp_d.out_byte  = crc_q[BYTE_W-1:0];
					end else begin
						load_rsp        = 1'b1;
						do_clear        = 1'b1;
						rsp_d.out_valid = 1'b1;
						rsp_d.out_last  = 1'b1;
						rsp_d.out_byte  = crc_q[CRC_W-1:BYTE_W];
					end
				end
			end
			S_FETCH: begin
				// Read data has arrived; the output slot was free when the read began.
				load_rsp        = 1'b1;
				rsp_d.out_valid = 1'b1;
				rsp_d.out_byte  = rd_data_s1;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Payload store: one write port for appends, one registered read port.
	always_ff @(posedge clk) begin
		if (do_append) begin
			store_q[count_q] <= cmd.data_byte;
		end
		if (do_read) begin
			rd_data_s1 <= store_q[rd_addr];
		end
	end

	// Frame count, CRC, emit position and emitting flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			crc_q      <= CRC_INIT;
			pos_q      <= '0;
			emitting_q <= 1'b0;
		end else if (do_clear) begin
			count_q    <= '0;
			crc_q      <= CRC_INIT;
			pos_q      <= '0;
			emitting_q <= 1'b0;
		end else if (do_append) begin
			count_q <= count_q + CNT_W'(1);
			crc_q   <= crc_next;
		end else if (do_advance) begin
			pos_q      <= pos_q + CNT_W'(1);
			emitting_q <= 1'b1;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
